// File: rtl/core/iabd_pkg.sv
// Package for the IMA ADPCM byte decoder: step and index tables, decoder state type.
// No dependencies; imported by iabd_nibble_dec and ima_adpcm_byte_decoder.
`timescale 1ns / 1ps

package iabd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 7;
  localparam int STEP_W   = 15;

  localparam logic [IDX_W-1:0] IDX_MAX = 7'd88;

  localparam logic signed [SAMPLE_W+1:0] PRED_MAX = 18'sd32767;
  localparam logic signed [SAMPLE_W+1:0] PRED_MIN = -18'sd32768;

  localparam logic [STEP_W-1:0] STEP_TABLE [89] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,
    15'd12,    15'd13,    15'd14,    15'd16,    15'd17,
    15'd19,    15'd21,    15'd23,    15'd25,    15'd28,
    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,
    15'd50,    15'd55,    15'd60,    15'd66,    15'd73,
    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
    15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
    15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
    15'd337,   15'd371,   15'd408,   15'd449,   15'd494,
    15'd544,   15'd598,   15'd658,   15'd724,   15'd796,
    15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,
    15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
    15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,
    15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
    15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,
    15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
    15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385,
    15'd24623, 15'd27086, 15'd29794, 15'd32767
  };

  // Decoder state carried from one nibble to the next.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] predictor;
    logic [IDX_W-1:0]           step_index;
  } dec_state_t;

  // Index table: the sign bit of the code does not matter.
  function automatic logic signed [4:0] idx_adjust(input logic [2:0] mag);
    logic signed [4:0] adj;
    case (mag) inside
      [3'd0:3'd3]: adj = -5'sd1;
      3'd4:        adj = 5'sd2;
      3'd5:        adj = 5'sd4;
      3'd6:        adj = 5'sd6;
      3'd7:        adj = 5'sd8;
      default:     adj = -5'sd1;
    endcase
    return adj;
  endfunction

endpackage

// File: rtl/core/iabd_nibble_dec.sv
// One 4-bit IMA ADPCM code step: table lookup, delta build, saturating add, index update.
// Depends on iabd_pkg.
`timescale 1ns / 1ps

module iabd_nibble_dec import iabd_pkg::*; (
  input  logic [3:0] code,
  input  dec_state_t state_cur,
  output dec_state_t state_new
);

  logic [IDX_W-1:0]         idx_eff;
  logic [STEP_W-1:0]        step;
  logic [SAMPLE_W-1:0]      delta;
  logic signed [SAMPLE_W+1:0] sum;
  logic signed [IDX_W:0]    idx_sum;

  always_comb begin
    // Treat an out-of-range index as the top entry.
    idx_eff = (state_cur.step_index > IDX_MAX) ? IDX_MAX : state_cur.step_index;
    step    = STEP_TABLE[idx_eff];

    delta = SAMPLE_W'(step >> 3);
    if (code[2]) delta = delta + SAMPLE_W'(step);
    if (code[1]) delta = delta + SAMPLE_W'(step >> 1);
    if (code[0]) delta = delta + SAMPLE_W'(step >> 2);

    if (code[3]) begin
      sum = (SAMPLE_W+2)'(state_cur.predictor) - $signed({2'b00, delta});
    end else begin
      sum = (SAMPLE_W+2)'(state_cur.predictor) + $signed({2'b00, delta});
    end

    if (sum > PRED_MAX) begin
      state_new.predictor = PRED_MAX[SAMPLE_W-1:0];
    end else if (sum < PRED_MIN) begin
      state_new.predictor = PRED_MIN[SAMPLE_W-1:0];
    end else begin
      state_new.predictor = sum[SAMPLE_W-1:0];
    end

    idx_sum = $signed({1'b0, idx_eff}) + (IDX_W+1)'(idx_adjust(code[2:0]));
    if (idx_sum < 0) begin
      state_new.step_index = '0;
    end else if (idx_sum > $signed({1'b0, IDX_MAX})) begin
      state_new.step_index = IDX_MAX;
    end else begin
      state_new.step_index = idx_sum[IDX_W-1:0];
    end
  end

endmodule

// File: rtl/core/ima_adpcm_byte_decoder.sv
// Top level of the IMA ADPCM byte decoder: input register, two chained nibble decoders,
// result register and the predictor / step index state. Depends on iabd_pkg, iabd_nibble_dec.
`timescale 1ns / 1ps

// Usage
//   Code channel: code_valid / code_stall carry one ADPCM byte (code_byte) and a
//   restart flag per transfer. Bits 3:0 are decoded first, then bits 7:4.
//   restart clears the predictor and step index before that byte is decoded,
//   as at the start of a clip.
//   PCM channel: pcm_valid / pcm_stall carry first_sample (from the low nibble)
//   and second_sample (from the high nibble) for every byte, in byte order.
//   Path: a transferred byte is held in the input register, decoded by the two
//   chained nibble decoders and presented with pcm_valid from the result register.
//   Throughput: one byte per cycle while the receiver does not stall. The two
//   nibble decodes sit between the input register and the result register;
//   that single chained path of table lookup, add and clamp sets the clock, not the rate.
//   Stall: when the receiver stalls, the result register holds its sample pair
//   and the input register still takes one more byte; only when both are full
//   does code_stall rise. Nothing is dropped.
//   Reset (rst, synchronous, active high): empty both registers, zero the
//   predictor and the step index.

module ima_adpcm_byte_decoder import iabd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       code_valid,
  output logic                       code_stall,
  input  logic [7:0]                 code_byte,
  input  logic                       restart,
  output logic                       pcm_valid,
  input  logic                       pcm_stall,
  output logic signed [SAMPLE_W-1:0] first_sample,
  output logic signed [SAMPLE_W-1:0] second_sample
);

  // Input register
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_restart;

  // Decoder state
  logic signed [SAMPLE_W-1:0] predictor;
  logic [IDX_W-1:0]           step_index;

  logic       advance;
  dec_state_t state_base;
  dec_state_t state_mid;
  dec_state_t state_end;

  // Move the decoded byte on whenever the result register is free or drains.
  assign advance    = !pcm_valid || !pcm_stall;
  assign code_stall = stage_valid && !advance;

  // Restart applies before the low nibble of the same byte.
  always_comb begin
    if (stage_restart) begin
      state_base.predictor  = '0;
      state_base.step_index = '0;
    end else begin
      state_base.predictor  = predictor;
      state_base.step_index = step_index;
    end
  end

  iabd_nibble_dec u_low_dec (
    .code      (stage_byte[3:0]),
    .state_cur (state_base),
    .state_new (state_mid)
  );

  iabd_nibble_dec u_high_dec (
    .code      (stage_byte[7:4]),
    .state_cur (state_mid),
    .state_new (state_end)
  );

  // Input register: load on every transfer, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!code_stall) begin
      stage_valid <= code_valid;
    end
    if (code_valid && !code_stall) begin
      stage_byte    <= code_byte;
      stage_restart <= restart;
    end
  end

  // Result register and state update: commit only when the byte moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      pcm_valid  <= 1'b0;
      predictor  <= '0;
      step_index <= '0;
    end else begin
      if (advance) begin
        pcm_valid <= stage_valid;
      end
      if (advance && stage_valid) begin
        predictor  <= state_end.predictor;
        step_index <= state_end.step_index;
      end
    end
    if (advance && stage_valid) begin
      first_sample  <= state_mid.predictor;
      second_sample <= state_end.predictor;
    end
  end

`ifndef ASSERT_OFF
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    step_index <= IDX_MAX)
    else $error("step index left its range");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> !code_stall)
    else $error("code channel stalled with an empty input register");

  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && advance) |=> pcm_valid)
    else $error("decoded byte did not reach the result register");

  a_restart_small: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && advance && stage_restart) |=>
      (first_sample <= 16'sd13 && first_sample >= -16'sd13))
    else $error("first sample after restart not from the smallest step");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !(stage_valid && advance) |=> ($stable(predictor) && $stable(step_index)))
    else $error("decoder state changed without a byte moving on");
`endif

endmodule
